>>> rtl/core/sslp_pkg.sv
// Shared types and constants for the segmented set list pool.
package sslp_pkg;

   localparam int ELEM_W = 10;
   localparam int LIST_W = 10;
   localparam int POS_W  = 6;
   localparam int CSR_W  = 15;
   localparam int STAT_W = 3;

   localparam logic [CSR_W-1:0] POOL_LIMIT_RESET = 15'd16384;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_READ   = 1'b1;

   localparam logic [STAT_W-1:0] STATUS_INSERTED  = 3'd0;
   localparam logic [STAT_W-1:0] STATUS_DUPLICATE = 3'd1;
   localparam logic [STAT_W-1:0] STATUS_EXHAUSTED = 3'd2;
   localparam logic [STAT_W-1:0] STATUS_FULL      = 3'd3;
   localparam logic [STAT_W-1:0] STATUS_READ      = 3'd4;

   typedef struct packed {
      logic              cmd;
      logic [LIST_W-1:0] list_id;
      logic [ELEM_W-1:0] element;
      logic [POS_W-1:0]  position;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ELEM_W-1:0] value;
      logic              value_valid;
   } rsp_type;

   typedef struct packed {
      logic lt;
      logic le;
   } cmp_type;

   typedef enum logic [7:0] {
      SEQ_CLEAR    = 8'b0000_0001,
      SEQ_IDLE     = 8'b0000_0010,
      SEQ_SEEK     = 8'b0000_0100,
      SEQ_LVL_RD   = 8'b0000_1000,
      SEQ_LVL_CHK  = 8'b0001_0000,
      SEQ_SLOT_RD  = 8'b0010_0000,
      SEQ_SLOT_CHK = 8'b0100_0000,
      SEQ_OUT      = 8'b1000_0000
   } seq_state_type;

endpackage

>>> rtl/core/segmented_set_list_pool.sv
// Top level of the segmented set list pool: sequencer, pool memories and configuration.
//
//   channel  direction  ports                          payload
//   req      in         req_valid, req_stall           req_payload (cmd, list_id, element, position)
//   rsp      out        rsp_valid, rsp_stall           rsp_payload (status, value, value_valid)
//   csr      in         csr_wr_en                      csr_wr_data (pool_limit)
//
// An insert visits the levels in order, reading the level memory for each one, and compares
// the slots of an allocated level one by one; the slot memory read and the one shared adder
// are used once per slot. A read first skips whole levels by its position, then reads at most one slot.
// After reset a clearing pass empties both memories; req_stall stays high meanwhile.
// One item is handled at a time; a finished result waits in the output register while the
// next item is accepted.
module segmented_set_list_pool import sslp_pkg::*; #(
   parameter int NUM_LISTS   = 1024,
   parameter int LEVEL_COUNT = 4,
   parameter int FIRST_SHIFT = 2,
   parameter int POOL_DEPTH  = 16384
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_payload,
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   localparam int LVL_DEPTH = NUM_LISTS * LEVEL_COUNT;
   localparam int LA        = (LVL_DEPTH > 1) ? $clog2(LVL_DEPTH) : 1;
   localparam int AW_P      = $clog2(POOL_DEPTH);
   localparam int CW        = $clog2(POOL_DEPTH + 1);
   localparam int SZ_W      = LEVEL_COUNT + FIRST_SHIFT;
   localparam int OFF_W     = (SZ_W > POS_W) ? SZ_W : POS_W;
   localparam int LV_W      = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
   localparam int SUM_W     = ((CW > OFF_W) ? CW : OFF_W) + 1;
   localparam int CLR_DEPTH = (LVL_DEPTH > POOL_DEPTH) ? LVL_DEPTH : POOL_DEPTH;
   localparam int CLR_W     = $clog2(CLR_DEPTH);
   localparam int LVL_DW    = AW_P + 1;
   localparam int SLOT_DW   = ELEM_W + 1;

   seq_state_type     state_ff, state_in;
   logic [CLR_W-1:0]  clr_ff, clr_in;
   logic [CW-1:0]     alloc_next_ff, alloc_next_in;
   logic [CSR_W-1:0]  pool_limit_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   rsp_type           res_ff, res_in;
   logic              cmd_ff, cmd_in;
   logic [ELEM_W-1:0] elem_ff, elem_in;
   logic [OFF_W-1:0]  pos_ff, pos_in;
   logic [LV_W-1:0]   lvl_ff, lvl_in;
   logic [LA-1:0]     kaddr_ff, kaddr_in;
   logic [AW_P-1:0]   base_ff, base_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   logic [AW_P-1:0]   slot_addr_ff, slot_addr_in;

   logic [CW-1:0]      lim;
   logic [OFF_W-1:0]   size;
   logic               last_lvl;
   logic [OFF_W-1:0]   off_next;
   logic [SUM_W-1:0]   op_a, op_b, sum;
   cmp_type            flags;
   logic               clearing;

   logic               lvl_wr_en;
   logic [LA-1:0]      lvl_wr_addr;
   logic [LVL_DW-1:0]  lvl_wr_data;
   logic [LVL_DW-1:0]  lvl_rd_data;
   logic               slot_wr_en;
   logic [AW_P-1:0]    slot_wr_addr;
   logic [SLOT_DW-1:0] slot_wr_data;
   logic [SLOT_DW-1:0] slot_rd_data;
   logic               alloc_ok;

   assign lim = (32'(pool_limit_ff) < POOL_DEPTH) ? CW'(pool_limit_ff) : CW'(POOL_DEPTH);
   assign size     = OFF_W'(1) << (lvl_ff + FIRST_SHIFT);
   assign last_lvl = (lvl_ff == LV_W'(LEVEL_COUNT - 1));
   assign off_next = off_ff + OFF_W'(1);
   assign clearing = (state_ff == SEQ_CLEAR);

   assign op_a = (state_ff == SEQ_LVL_CHK) ? SUM_W'(alloc_next_ff) : SUM_W'(base_ff);
   assign op_b = (state_ff == SEQ_LVL_CHK) ? SUM_W'(size) : SUM_W'(off_ff);

   sslp_step_unit #(.SUM_W(SUM_W)) u_step (
      .op_a  (op_a),
      .op_b  (op_b),
      .limit (SUM_W'(lim)),
      .sum   (sum),
      .flags (flags)
   );

   assign alloc_ok = (state_ff == SEQ_LVL_CHK) && (cmd_ff == CMD_INSERT) &&
                     !lvl_rd_data[AW_P] && flags.le;

   always_comb begin
      if (clearing) begin
         lvl_wr_en    = (32'(clr_ff) < LVL_DEPTH);
         lvl_wr_addr  = LA'(clr_ff);
         lvl_wr_data  = '0;
         slot_wr_en   = (32'(clr_ff) < POOL_DEPTH);
         slot_wr_addr = AW_P'(clr_ff);
         slot_wr_data = '0;
      end else begin
         lvl_wr_en    = alloc_ok;
         lvl_wr_addr  = kaddr_ff;
         lvl_wr_data  = {1'b1, AW_P'(alloc_next_ff)};
         slot_wr_data = {1'b1, elem_ff};
         if (alloc_ok) begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = AW_P'(alloc_next_ff);
         end else begin
            slot_wr_en   = (state_ff == SEQ_SLOT_CHK) && (cmd_ff == CMD_INSERT) &&
                           !slot_rd_data[ELEM_W];
            slot_wr_addr = slot_addr_ff;
         end
      end
   end

   sslp_ram #(.DEPTH(LVL_DEPTH), .WIDTH(LVL_DW)) u_level_mem (
      .clock   (clock),
      .wr_en   (lvl_wr_en),
      .wr_addr (lvl_wr_addr),
      .wr_data (lvl_wr_data),
      .rd_addr (kaddr_ff),
      .rd_data (lvl_rd_data)
   );

   sslp_ram #(.DEPTH(POOL_DEPTH), .WIDTH(SLOT_DW)) u_slot_mem (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_addr (AW_P'(sum)),
      .rd_data (slot_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      alloc_next_in = alloc_next_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      res_in        = res_ff;
      cmd_in        = cmd_ff;
      elem_in       = elem_ff;
      pos_in        = pos_ff;
      lvl_in        = lvl_ff;
      kaddr_in      = kaddr_ff;
      base_in       = base_ff;
      off_in        = off_ff;
      slot_addr_in  = slot_addr_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         SEQ_CLEAR: begin
            clr_in = clr_ff + CLR_W'(1);
            if (clr_ff == CLR_W'(CLR_DEPTH - 1)) begin
               state_in = SEQ_IDLE;
            end
         end
         SEQ_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_payload.cmd;
               elem_in  = req_payload.element;
               pos_in   = OFF_W'(req_payload.position);
               lvl_in   = '0;
               kaddr_in = LA'(32'(req_payload.list_id) * LEVEL_COUNT);
               res_in   = '0;
               if (32'(req_payload.list_id) >= NUM_LISTS) begin
                  res_in.status = (req_payload.cmd == CMD_READ) ? STATUS_READ
                                                                : STATUS_EXHAUSTED;
                  state_in      = SEQ_OUT;
               end else if (req_payload.cmd == CMD_READ) begin
                  state_in = SEQ_SEEK;
               end else begin
                  state_in = SEQ_LVL_RD;
               end
            end
         end
         SEQ_SEEK: begin
            if (pos_ff >= size) begin
               pos_in = pos_ff - size;
               if (last_lvl) begin
                  res_in.status = STATUS_READ;
                  state_in      = SEQ_OUT;
               end else begin
                  lvl_in   = lvl_ff + LV_W'(1);
                  kaddr_in = kaddr_ff + LA'(1);
               end
            end else begin
               state_in = SEQ_LVL_RD;
            end
         end
         SEQ_LVL_RD: begin
            state_in = SEQ_LVL_CHK;
         end
         SEQ_LVL_CHK: begin
            if (!lvl_rd_data[AW_P]) begin
               state_in = SEQ_OUT;
               if (cmd_ff == CMD_READ) begin
                  res_in.status = STATUS_READ;
               end else if (flags.le) begin
                  alloc_next_in = CW'(sum);
                  res_in.status = STATUS_INSERTED;
               end else begin
                  res_in.status = STATUS_FULL;
               end
            end else begin
               base_in  = lvl_rd_data[AW_P-1:0];
               off_in   = (cmd_ff == CMD_READ) ? pos_ff : '0;
               state_in = SEQ_SLOT_RD;
            end
         end
         SEQ_SLOT_RD: begin
            slot_addr_in = AW_P'(sum);
            if (!flags.lt) begin
               res_in.status = (cmd_ff == CMD_READ) ? STATUS_READ : STATUS_FULL;
               state_in      = SEQ_OUT;
            end else begin
               state_in = SEQ_SLOT_CHK;
            end
         end
         SEQ_SLOT_CHK: begin
            if (cmd_ff == CMD_READ) begin
               res_in.status      = STATUS_READ;
               res_in.value_valid = slot_rd_data[ELEM_W];
               res_in.value       = slot_rd_data[ELEM_W] ? slot_rd_data[ELEM_W-1:0] : '0;
               state_in           = SEQ_OUT;
            end else if (!slot_rd_data[ELEM_W]) begin
               res_in.status = STATUS_INSERTED;
               state_in      = SEQ_OUT;
            end else if (slot_rd_data[ELEM_W-1:0] == elem_ff) begin
               res_in.status = STATUS_DUPLICATE;
               state_in      = SEQ_OUT;
            end else if (off_next == size) begin
               if (last_lvl) begin
                  res_in.status = STATUS_EXHAUSTED;
                  state_in      = SEQ_OUT;
               end else begin
                  lvl_in   = lvl_ff + LV_W'(1);
                  kaddr_in = kaddr_ff + LA'(1);
                  state_in = SEQ_LVL_RD;
               end
            end else begin
               off_in   = off_next;
               state_in = SEQ_SLOT_RD;
            end
         end
         SEQ_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_CLEAR;
         clr_ff        <= '0;
         alloc_next_ff <= '0;
         pool_limit_ff <= POOL_LIMIT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         alloc_next_ff <= alloc_next_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            pool_limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff       <= rsp_in;
      res_ff       <= res_in;
      cmd_ff       <= cmd_in;
      elem_ff      <= elem_in;
      pos_ff       <= pos_in;
      lvl_ff       <= lvl_in;
      kaddr_ff     <= kaddr_in;
      base_ff      <= base_in;
      off_ff       <= off_in;
      slot_addr_ff <= slot_addr_in;
   end

   assign req_stall   = (state_ff != SEQ_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == SEQ_OUT))
      else $error("Result appeared without leaving the output state.");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != SEQ_IDLE))
      else $error("Sequencer idle in the cycle after a transfer was accepted.");

   a_bump_in_pool: assert property (@(posedge clock) disable iff (reset)
      32'(alloc_next_ff) <= POOL_DEPTH)
      else $error("Bump pointer passed the end of the pool.");

   a_insert_no_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != STATUS_READ)) |->
         (!rsp_ff.value_valid && (rsp_ff.value == '0)))
      else $error("Insert result carries a read value.");

endmodule

>>> rtl/core/sslp_ram.sv
// Single-port-write, single-port-read memory with registered read data.
module sslp_ram #(
   parameter int DEPTH  = 64,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

>>> rtl/core/sslp_step_unit.sv
// Shared adder and limit comparator used for slot addresses and block allocation.
module sslp_step_unit import sslp_pkg::*; #(
   parameter int SUM_W = 16
) (
   input  logic [SUM_W-1:0] op_a,
   input  logic [SUM_W-1:0] op_b,
   input  logic [SUM_W-1:0] limit,
   output logic [SUM_W-1:0] sum,
   output cmp_type          flags
);

   assign sum      = op_a + op_b;
   assign flags.lt = (sum < limit);
   assign flags.le = (sum <= limit);

endmodule

>>> dv/segmented_set_list_pool_tb.sv
// Self-checking testbench for the segmented set list pool, with its own pool predictor.
module segmented_set_list_pool_tb;
   import sslp_pkg::*;

   localparam int N_LISTS        = 1024;
   localparam int N_LEVELS       = 4;
   localparam int FIRST_SHIFT    = 2;
   localparam int POOL_DEPTH     = 16384;
   localparam int WATCHDOG_LIMIT = 80000;
   localparam int HOLD_CYCLES    = 600;
   localparam int TAIL_CYCLES    = 200;

   class pool_scoreboard;
      logic [CSR_W-1:0]  lvl_base [N_LISTS*N_LEVELS];
      bit                lvl_alloc [N_LISTS*N_LEVELS];
      logic [ELEM_W-1:0] slot_elem [POOL_DEPTH];
      bit                slot_used [POOL_DEPTH];
      int unsigned       alloc_next;
      logic [CSR_W-1:0]  pool_limit;
      rsp_type           expected_rsp[$];
      int                errors;
      int                n_checked;
      int                status_seen [8];
      int                read_hits;

      function new();
         alloc_next = 0;
         pool_limit = POOL_LIMIT_RESET;
         errors     = 0;
         n_checked  = 0;
         read_hits  = 0;
      endfunction

      function int unsigned usable_limit();
         return (pool_limit < POOL_DEPTH) ? pool_limit : POOL_DEPTH;
      endfunction

      function logic [STAT_W-1:0] insert_into_list(int unsigned list,
                                                   logic [ELEM_W-1:0] elem);
         int unsigned lim, k, size, s;
         lim = usable_limit();
         if (list >= N_LISTS) return STATUS_EXHAUSTED;
         for (int unsigned lvl = 0; lvl < N_LEVELS; lvl++) begin
            k    = list * N_LEVELS + lvl;
            size = 1 << (lvl + FIRST_SHIFT);
            if (!lvl_alloc[k]) begin
               if (alloc_next > lim || size > lim - alloc_next) return STATUS_FULL;
               lvl_base[k]           = CSR_W'(alloc_next);
               lvl_alloc[k]          = 1'b1;
               slot_elem[alloc_next] = elem;
               slot_used[alloc_next] = 1'b1;
               alloc_next           += size;
               return STATUS_INSERTED;
            end
            for (int unsigned i = 0; i < size; i++) begin
               s = lvl_base[k] + i;
               if (s >= lim) return STATUS_FULL;
               if (!slot_used[s]) begin
                  slot_elem[s] = elem;
                  slot_used[s] = 1'b1;
                  return STATUS_INSERTED;
               end
               if (slot_elem[s] == elem) return STATUS_DUPLICATE;
            end
         end
         return STATUS_EXHAUSTED;
      endfunction

      function bit read_list_at(int unsigned list, int unsigned pos,
                                output logic [ELEM_W-1:0] val);
         int unsigned lim, k, size, s;
         val = '0;
         lim = usable_limit();
         if (list >= N_LISTS) return 1'b0;
         for (int unsigned lvl = 0; lvl < N_LEVELS; lvl++) begin
            size = 1 << (lvl + FIRST_SHIFT);
            if (pos >= size) begin
               pos -= size;
               continue;
            end
            k = list * N_LEVELS + lvl;
            if (!lvl_alloc[k]) return 1'b0;
            s = lvl_base[k] + pos;
            if (s >= lim || !slot_used[s]) return 1'b0;
            val = slot_elem[s];
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void accept_request(req_type r);
         rsp_type           e;
         logic [ELEM_W-1:0] v;
         e = '0;
         if (r.cmd == CMD_INSERT) begin
            e.status = insert_into_list(r.list_id, r.element);
         end else begin
            e.status      = STATUS_READ;
            e.value_valid = read_list_at(r.list_id, r.position, v);
            e.value       = v;
         end
         expected_rsp.push_back(e);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (expected_rsp.size() == 0) begin
            $error("unexpected result transfer: status %0d value %0d valid %0d",
                   got.status, got.value, got.value_valid);
            errors++;
            return;
         end
         want = expected_rsp.pop_front();
         n_checked++;
         status_seen[want.status]++;
         if (want.value_valid) read_hits++;
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, got.value);
            errors++;
         end
         if (got.value_valid !== want.value_valid) begin
            $error("value_valid: expected %0d, got %0d", want.value_valid, got.value_valid);
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   req_type          req_payload;
   logic             rsp_valid;
   logic             rsp_stall;
   rsp_type          rsp_payload;
   logic             csr_wr_en;
   logic [CSR_W-1:0] csr_wr_data;

   pool_scoreboard sb = new();
   bit             idle_on = 1'b1;
   int             sent = 0;
   int             idle_cycles = 0;
   int unsigned    hot_list [6];

   segmented_set_list_pool #(
      .NUM_LISTS   (N_LISTS),
      .LEVEL_COUNT (N_LEVELS),
      .FIRST_SHIFT (FIRST_SHIFT),
      .POOL_DEPTH  (POOL_DEPTH)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d cycles without a transfer.", idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // The receiver holds off once for a long stretch so that the block backs up.
   initial begin
      int hold_left;
      bit pressure_done;
      hold_left     = 0;
      pressure_done = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_payload);
         if (!pressure_done && sb.n_checked >= 150) begin
            hold_left     = HOLD_CYCLES;
            pressure_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= idle_on && ($urandom_range(0, 99) < 29);
         end
      end
   end

   task automatic send_item(input req_type item);
      while (idle_on && $urandom_range(0, 99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      sb.accept_request(item);
      sent++;
   endtask

   task automatic insert_req(input int unsigned list, input int unsigned elem);
      req_type r;
      r.cmd      = CMD_INSERT;
      r.list_id  = LIST_W'(list);
      r.element  = ELEM_W'(elem);
      r.position = POS_W'($urandom_range(0, 63));
      send_item(r);
   endtask

   task automatic read_req(input int unsigned list, input int unsigned pos);
      req_type r;
      r.cmd      = CMD_READ;
      r.list_id  = LIST_W'(list);
      r.element  = ELEM_W'($urandom_range(0, 1023));
      r.position = POS_W'(pos);
      send_item(r);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_limit(input int unsigned limit);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CSR_W'(limit);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.pool_limit = CSR_W'(limit);
   endtask

   task automatic run_random(input int target);
      int unsigned list, len, base, win, j;
      bit          ascending;
      req_type     r;
      while (sent < target) begin
         if ($urandom_range(0, 99) < 80) begin
            list      = ($urandom_range(0, 99) < 70) ? hot_list[$urandom_range(0, 5)]
                                                     : $urandom_range(0, 1023);
            len       = $urandom_range(8, 70);
            ascending = $urandom_range(0, 1);
            base      = $urandom_range(0, 1023);
            win       = $urandom_range(8, 100);
            for (j = 0; j < len && sent < target; j++) begin
               if ($urandom_range(0, 99) < 20) read_req(list, $urandom_range(0, 63));
               else if (ascending) insert_req(list, base + j);
               else insert_req(list, base + $urandom_range(0, win));
            end
         end else begin
            len = $urandom_range(1, 4);
            for (j = 0; j < len && sent < target; j++) begin
               r.cmd      = 1'($urandom_range(0, 1));
               r.list_id  = LIST_W'($urandom_range(0, 1023));
               r.element  = ELEM_W'($urandom_range(0, 1023));
               r.position = POS_W'($urandom_range(0, 63));
               send_item(r);
            end
         end
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      hot_list[0] = 0;
      hot_list[1] = 1023;
      for (int i = 2; i < 6; i++) hot_list[i] = $urandom_range(0, 1023);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      insert_req(0, 0);
      insert_req(0, 0);
      insert_req(1023, 1023);
      insert_req(0, 'h2AA);
      insert_req('h155, 'h155);
      read_req(0, 0);
      read_req(0, 1);
      read_req(0, 2);
      read_req(0, 4);
      read_req(0, 59);
      read_req(0, 60);
      read_req(0, 63);
      read_req(1023, 0);
      read_req('h2AA, 'h2A);
      read_req('h155, 'h15);
      insert_req(0, 1);
      insert_req(0, 2);
      insert_req(0, 3);
      insert_req(0, 3);
      read_req(0, 4);
      read_req(0, 3);

      run_random(120);
      idle_on = 1'b0;
      run_random(220);
      idle_on = 1'b1;
      run_random(300);

      drain();
      write_limit(32767);
      run_random(380);

      // Room for a few small blocks only, so that larger levels no longer fit.
      drain();
      write_limit(sb.alloc_next + 12);
      run_random(440);

      // Lowered below blocks already handed out.
      drain();
      write_limit(sb.alloc_next / 2);
      run_random(500);

      drain();
      write_limit(0);
      run_random(540);

      drain();
      write_limit(POOL_LIMIT_RESET);
      run_random(620);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d request transfers and %0d checked results, %0d pool slots used.",
               sent, sb.n_checked, sb.alloc_next);
      $display("Outcomes: %0d inserted, %0d duplicate, %0d exhausted, %0d full, %0d reads (%0d hits).",
               sb.status_seen[STATUS_INSERTED], sb.status_seen[STATUS_DUPLICATE],
               sb.status_seen[STATUS_EXHAUSTED], sb.status_seen[STATUS_FULL],
               sb.status_seen[STATUS_READ], sb.read_hits);
      if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
